// ===== rtl/core/mrtt_pkg.sv =====
// ----------------------------------------------------------------------------
// mrtt_pkg
// shared types and codes for the memory range type table
// ----------------------------------------------------------------------------
package mrtt_pkg;

  localparam int ADDR_W = 64;
  localparam int TYPE_W = 4;
  localparam int CAP_W  = 6;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 6;
  localparam int CFG_IDX_W = 1;

  // transaction kinds
  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // add status codes
  localparam logic [STAT_W-1:0] STAT_STORED       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OUT_OF_ORDER = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_TYPE = 1'b1;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  // one stored range: base, exclusive limit, type code
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] lim;
    logic [TYPE_W-1:0] kind;
  } entry_t;

  // configuration seen by the controller
  typedef struct packed {
    logic [CAP_W-1:0]  capacity;
    logic [TYPE_W-1:0] reserved_type;
    logic              clear;
  } cfg_t;

endpackage

// ===== rtl/core/mrtt_ram.sv =====
// ----------------------------------------------------------------------------
// mrtt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mrtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/mrtt_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrtt_ctrl
// append and scan sequencer around the range ram
// ----------------------------------------------------------------------------
module mrtt_ctrl #(
  parameter int MAX_RANGES = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mrtt_pkg::cfg_t                      cfg,
  input  logic                                start,
  output logic                                busy,
  input  logic                                mode,
  input  logic [mrtt_pkg::ADDR_W-1:0]         range_start,
  input  logic [mrtt_pkg::ADDR_W-1:0]         range_end,
  input  logic [mrtt_pkg::TYPE_W-1:0]         range_type,
  input  logic [mrtt_pkg::ADDR_W-1:0]         query_address,
  output logic                                done,
  output logic [mrtt_pkg::TYPE_W-1:0]         found_type,
  output logic                                hit,
  output logic [mrtt_pkg::STAT_W-1:0]         add_status,
  output logic                                ram_wr_en,
  output logic [((MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1)-1:0] ram_wr_addr,
  output mrtt_pkg::entry_t                    ram_wr_data,
  output logic [((MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1)-1:0] ram_rd_addr,
  input  mrtt_pkg::entry_t                    ram_rd_data
);
  import mrtt_pkg::*;

  localparam int AW    = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W = $clog2(MAX_RANGES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  ptr, ptr_next;
  logic              pend, pend_next;
  logic [ADDR_W-1:0] last_end;
  logic [ADDR_W-1:0] query;
  logic [CNT_W-1:0]  cap_eff;
  logic              accept, add_acc, full, add_store, out_of_order;
  logic              issue, match, fin, fin_hit;

  // effective capacity is min(capacity, table depth)
  always_comb begin
    if (CMP_W'(cfg.capacity) >= CMP_W'(MAX_RANGES)) begin
      cap_eff = CNT_W'(MAX_RANGES);
    end else begin
      cap_eff = CNT_W'(cfg.capacity);
    end
  end

  assign busy         = (state != S_IDLE);
  assign accept       = start && !busy;
  assign add_acc      = accept && (mode == MODE_ADD);
  assign full         = (count >= cap_eff);
  assign add_store    = add_acc && !full;
  assign out_of_order = (count != '0) && (range_start < last_end);

  assign ram_wr_en   = add_store;
  assign ram_wr_addr = count[AW-1:0];
  assign ram_wr_data = '{base: range_start, lim: range_end, kind: range_type};
  assign ram_rd_addr = ptr[AW-1:0];

  assign match = (ram_rd_data.base <= query) && (query < ram_rd_data.lim);

  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    pend_next  = 1'b0;
    issue      = 1'b0;
    fin        = 1'b0;
    fin_hit    = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept && (mode == MODE_LOOKUP)) begin
          state_next = S_SCAN;
          ptr_next   = '0;
        end
      end
      S_SCAN: begin
        issue = (ptr < count);
        if (pend && match) begin
          fin        = 1'b1;
          fin_hit    = 1'b1;
          state_next = S_IDLE;
        end else if (!issue && !pend) begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end else begin
          pend_next = issue;
          if (issue) begin
            ptr_next = ptr + CNT_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      done  <= add_acc || fin;
      if (cfg.clear) begin
        count <= '0;
      end else if (add_store) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (accept) begin
      query <= query_address;
    end
    if (add_store) begin
      last_end <= range_end;
    end
    if (fin) begin
      found_type <= fin_hit ? ram_rd_data.kind : cfg.reserved_type;
    end else begin
      found_type <= '0;
    end
    hit <= fin_hit;
    if (!add_acc) begin
      add_status <= STAT_STORED;
    end else if (full) begin
      add_status <= STAT_OVERFLOW;
    end else if (out_of_order) begin
      add_status <= STAT_OUT_OF_ORDER;
    end else begin
      add_status <= STAT_STORED;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_RANGES))
    else $error("entry count beyond table depth");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a scan is still running");

  a_pend_scan: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == S_SCAN))
    else $error("ram read pending outside a scan");

  a_append: assert property (@(posedge clk) disable iff (rst)
    (add_store && !cfg.clear) |=> (count == $past(count) + CNT_W'(1)))
    else $error("stored range did not advance the count");
`endif

endmodule

// ===== rtl/core/memory_range_type_table_unit.sv =====
// ----------------------------------------------------------------------------
// memory_range_type_table_unit
// appended table of memory ranges with first-match type lookup
// ----------------------------------------------------------------------------
//
// channel  direction  handshake                    payload
// -------  ---------  ---------------------------  ------------------------------------
// item     in         start high while busy low    mode, range_start, range_end,
//                                                  range_type, query_address
// result   out        done high for one cycle      found_type, hit, add_status
// config   in         cfg_we high                  cfg_index, cfg_data
//
// an add transaction shows its result the cycle after accept
// a lookup keeps busy high while it scans and its result shows in the same
//   cycle that busy falls: the single ram read port walks the stored
//   entries one per cycle, stopping at the first match
// busy is high only while a lookup scan runs; adds can follow back to back
// reset returns capacity to 32, reserved type to 0 and empties the table
// the receiver cannot stall: each result is on the ports for one cycle only
// ----------------------------------------------------------------------------
module memory_range_type_table_unit #(
  parameter int MAX_RANGES = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // item channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 mode,
  input  logic [mrtt_pkg::ADDR_W-1:0]          range_start,
  input  logic [mrtt_pkg::ADDR_W-1:0]          range_end,
  input  logic [mrtt_pkg::TYPE_W-1:0]          range_type,
  input  logic [mrtt_pkg::ADDR_W-1:0]          query_address,
  // result channel
  output logic                                 done,
  output logic [mrtt_pkg::TYPE_W-1:0]          found_type,
  output logic                                 hit,
  output logic [mrtt_pkg::STAT_W-1:0]          add_status,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [mrtt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mrtt_pkg::CFG_W-1:0]           cfg_data
);
  import mrtt_pkg::*;

  localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

  logic [CAP_W-1:0]  capacity;
  logic [TYPE_W-1:0] reserved_type;
  cfg_t              cfg;

  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  entry_t            ram_wr_data;
  logic [AW-1:0]     ram_rd_addr;
  entry_t            ram_rd_data;

  // configuration registers; a capacity write also empties the table
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= CAP_W'(32);
      reserved_type <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAPACITY:      capacity      <= cfg_data[CAP_W-1:0];
        REG_RESERVED_TYPE: reserved_type <= cfg_data[TYPE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.capacity      = capacity;
  assign cfg.reserved_type = reserved_type;
  assign cfg.clear         = cfg_we && (cfg_index == REG_CAPACITY);

  // range storage: base, limit and type packed into one word per entry
  mrtt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_RANGES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // append and scan sequencer
  mrtt_ctrl #(
    .MAX_RANGES (MAX_RANGES)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .range_start   (range_start),
    .range_end     (range_end),
    .range_type    (range_type),
    .query_address (query_address),
    .done          (done),
    .found_type    (found_type),
    .hit           (hit),
    .add_status    (add_status),
    .ram_wr_en     (ram_wr_en),
    .ram_wr_addr   (ram_wr_addr),
    .ram_wr_data   (ram_wr_data),
    .ram_rd_addr   (ram_rd_addr),
    .ram_rd_data   (ram_rd_data)
  );

endmodule

// ===== test/memory_range_type_table_unit_test.sv =====
// ----------------------------------------------------------------------------
// memory_range_type_table_unit_test
// self-checking bench for the memory range type table
//
// builds the range table alongside the block and predicts the reply to every
// add and lookup transaction; directed cases hit the address extremes,
// overlapping and inverted ranges, the out-of-order flag and the capacity
// limits, then random phases fill the table under many capacity and reserved
// type settings with the sender idling in random bursts
// ----------------------------------------------------------------------------
module memory_range_type_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mrtt_pkg::*;

  localparam int TABLE_DEPTH   = 32;
  localparam int IDLE_LIMIT    = 2000;  // cycles with no activity before giving up
  localparam int REPORT_LIMIT  = 10;
  localparam int RANDOM_PHASES = 24;
  localparam int PHASE_ITEMS   = 80;

  // one item as seen on the input ports
  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] range_start;
    logic [ADDR_W-1:0] range_end;
    logic [TYPE_W-1:0] range_type;
    logic [ADDR_W-1:0] query_address;
  } table_item_t;

  // one reply as seen on the result ports
  typedef struct packed {
    logic [TYPE_W-1:0] found_type;
    logic              hit;
    logic [STAT_W-1:0] add_status;
  } table_reply_t;

  // every input is known from time zero
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              mode = MODE_ADD;
  logic [ADDR_W-1:0] range_start = '0;
  logic [ADDR_W-1:0] range_end = '0;
  logic [TYPE_W-1:0] range_type = '0;
  logic [ADDR_W-1:0] query_address = '0;
  logic              cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_CAPACITY;
  logic [CFG_W-1:0]  cfg_data = '0;

  logic              busy;
  logic              done;
  logic [TYPE_W-1:0] found_type;
  logic              hit;
  logic [STAT_W-1:0] add_status;

  memory_range_type_table_unit #(
    .MAX_RANGES(TABLE_DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .range_start  (range_start),
    .range_end    (range_end),
    .range_type   (range_type),
    .query_address(query_address),
    .done         (done),
    .found_type   (found_type),
    .hit          (hit),
    .add_status   (add_status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // shadow copy of the range table and its registers
  // --------------------------------------------------------------------------
  entry_t            shadow_ranges [TABLE_DEPTH];
  int unsigned       shadow_count = 0;
  logic [CAP_W-1:0]  shadow_capacity = 6'd32;
  logic [TYPE_W-1:0] shadow_reserved = '0;

  table_reply_t      pending_replies [$];   // oldest expected reply at the front
  int                mismatch_count = 0;

  // sender pacing
  int unsigned       burst_left = 0;
  bit                gaps_on = 1'b1;
  logic [ADDR_W-1:0] add_cursor = '0;       // end of the last generated range

  // applies one transaction to the shadow table and returns the reply it causes
  function automatic table_reply_t predict_table_reply(input table_item_t it);
    table_reply_t r;
    int unsigned  room;
    int unsigned  i;
    r = '0;
    room = (shadow_capacity < TABLE_DEPTH) ? shadow_capacity : TABLE_DEPTH;
    if (it.mode == MODE_ADD) begin
      if (shadow_count >= room) begin
        r.add_status = STAT_OVERFLOW;
      end else begin
        // only the most recently stored range counts for ordering
        if (shadow_count > 0 && it.range_start < shadow_ranges[shadow_count-1].lim) begin
          r.add_status = STAT_OUT_OF_ORDER;
        end
        shadow_ranges[shadow_count].base = it.range_start;
        shadow_ranges[shadow_count].lim  = it.range_end;
        shadow_ranges[shadow_count].kind = it.range_type;
        shadow_count++;
      end
    end else begin
      // first stored range in insertion order wins, end is exclusive
      r.found_type = shadow_reserved;
      for (i = 0; i < shadow_count; i++) begin
        if (!r.hit && shadow_ranges[i].base <= it.query_address &&
            it.query_address < shadow_ranges[i].lim) begin
          r.found_type = shadow_ranges[i].kind;
          r.hit = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // unused fields carry random values so every port bit moves
  function automatic table_item_t make_add(input logic [ADDR_W-1:0] first,
                                           input logic [ADDR_W-1:0] past,
                                           input logic [TYPE_W-1:0] kind);
    table_item_t it;
    it.mode          = MODE_ADD;
    it.range_start   = first;
    it.range_end     = past;
    it.range_type    = kind;
    it.query_address = rand64();
    return it;
  endfunction

  function automatic table_item_t make_lookup(input logic [ADDR_W-1:0] addr);
    table_item_t it;
    it.mode          = MODE_LOOKUP;
    it.range_start   = rand64();
    it.range_end     = rand64();
    it.range_type    = TYPE_W'($urandom);
    it.query_address = addr;
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // driving
  // --------------------------------------------------------------------------

  // called at a rising edge; returns at the edge that accepts the transaction
  task automatic send_item(input table_item_t it);
    start         <= 1'b1;
    mode          <= it.mode;
    range_start   <= it.range_start;
    range_end     <= it.range_end;
    range_type    <= it.range_type;
    query_address <= it.query_address;
    do @(posedge clk); while (busy);
    pending_replies.push_back(predict_table_reply(it));
    // bursts of random length, random gaps between them
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if (gaps_on) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  endtask

  // hold the sender until every reply is in and the block is idle again
  task automatic wait_for_replies();
    start <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0 || busy) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == REG_CAPACITY) begin
      shadow_capacity = data;
      shadow_count = 0;  // capacity write empties the table
    end else begin
      shadow_reserved = data[TYPE_W-1:0];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // random stimulus helpers
  // --------------------------------------------------------------------------

  // mostly ranges laid out in ascending order, with some overlap, empty,
  // inverted, wild and edge-of-space ranges mixed in
  function automatic table_item_t random_add();
    logic [ADDR_W-1:0] first;
    logic [ADDR_W-1:0] past;
    logic [ADDR_W-1:0] len;
    len = (rand64() >> $urandom_range(40, 63)) + 1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        first = add_cursor;
        if ($urandom_range(0, 2) != 0) first = first + (rand64() >> $urandom_range(44, 63));
        past = first + len;
      end
      6: begin
        first = add_cursor - len;  // starts below the last end
        past  = first + len;
      end
      7: begin
        first = add_cursor;
        past  = $urandom_range(0, 1) ? first : first - len;
      end
      8: begin
        first = rand64();
        past  = rand64();
      end
      default: begin
        first = $urandom_range(0, 1) ? '0 : '1 - len;
        past  = $urandom_range(0, 1) ? '1 : first + len;
      end
    endcase
    add_cursor = past;
    return make_add(first, past, TYPE_W'($urandom));
  endfunction

  // probes mostly land on or next to the edges of stored ranges
  function automatic logic [ADDR_W-1:0] probe_address();
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    int unsigned       i;
    if (shadow_count != 0 && $urandom_range(0, 3) != 0) begin
      i  = $urandom_range(0, shadow_count - 1);
      lo = shadow_ranges[i].base;
      hi = shadow_ranges[i].lim;
      case ($urandom_range(0, 4))
        0: return lo;
        1: return hi - 1;
        2: return hi;
        3: return lo - 1;
        default: return (hi > lo) ? lo + rand64() % (hi - lo) : lo;
      endcase
    end
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return rand64() >> $urandom_range(0, 63);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // lookups on the empty table after reset fall back to the reserved type
  task automatic test_empty_table();
    send_item(make_lookup('0));
    send_item(make_lookup('1));
  endtask

  // overlapping, touching, empty and inverted ranges with probes on their edges
  task automatic test_ranges_and_boundaries();
    send_item(make_add(64'h1000, 64'h2000, 4'd3));
    send_item(make_add(64'h2000, 64'h3000, 4'd7));   // touching the previous end: in order
    send_item(make_add(64'h1800, 64'h2800, 4'd12));  // overlaps: out of order
    send_item(make_add('0, '0, 4'd5));               // empty range, also out of order
    send_item(make_add(64'hFFFF_FFFF_FFFF_FFF0, '1, 4'd15));
    send_item(make_add('1, '0, 4'd1));               // inverted range matches nothing
    send_item(make_add('0, '1, 4'd0));               // covers all but the top address
    send_item(make_lookup('0));
    send_item(make_lookup(64'h0FFF));
    send_item(make_lookup(64'h1000));
    send_item(make_lookup(64'h1FFF));
    send_item(make_lookup(64'h2000));
    send_item(make_lookup(64'h2800));  // first match in insertion order wins
    send_item(make_lookup(64'h3000));
    send_item(make_lookup('1 - 1));
    send_item(make_lookup('1));        // exclusive end: falls to the reserved type
  endtask

  // zero capacity drops everything, capacity one takes a single range
  task automatic test_capacity_limits();
    wait_for_replies();
    write_reg(REG_CAPACITY, '0);
    send_item(make_add(64'h100, 64'h200, 4'd9));
    send_item(make_lookup(64'h180));
    wait_for_replies();
    write_reg(REG_CAPACITY, 6'd1);
    write_reg(REG_RESERVED_TYPE, 6'h3F);  // upper data bits are dropped
    send_item(make_add(64'h100, 64'h200, 4'd9));
    send_item(make_add(64'h200, 64'h300, 4'd6));
    send_item(make_lookup(64'h180));
    send_item(make_lookup(64'h280));
  endtask

  // phases under different settings; each capacity write starts a fresh table
  task automatic test_random_traffic();
    logic [CFG_W-1:0] cap;
    logic [CFG_W-1:0] res;
    int               n;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 8)
        0: cap = 6'd0;
        1: cap = 6'd1;
        2: cap = 6'd63;
        3: cap = 6'd32;
        4: cap = 6'd33;
        5: cap = 6'd31;
        6: cap = 6'd2;
        default: cap = CFG_W'($urandom_range(0, 63));
      endcase
      case (phase % 5)
        0: res = '0;
        1: res = 6'h3F;
        default: res = CFG_W'($urandom_range(0, 63));
      endcase
      wait_for_replies();
      write_reg(REG_RESERVED_TYPE, res);
      write_reg(REG_CAPACITY, cap);
      gaps_on    = (phase % 3) != 2;  // every third phase runs flat out
      add_cursor = rand64() >> $urandom_range(0, 63);
      n = PHASE_ITEMS;
      while (n > 0) begin
        if ($urandom_range(0, 99) < 45) send_item(random_add());
        else send_item(make_lookup(probe_address()));
        n--;
        if ($urandom_range(0, 31) == 0) wait_for_replies();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input logic [7:0] want,
                               input logic [7:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  // results cannot be held off: each one is sampled on the edge closing its cycle
  always @(posedge clk) begin
    table_reply_t want;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        note_mismatch("unexpected result", 8'(0), 8'({found_type, hit, add_status}));
      end else begin
        want = pending_replies.pop_front();
        if (found_type !== want.found_type) begin
          note_mismatch("found_type", 8'(want.found_type), 8'(found_type));
        end
        if (hit !== want.hit) begin
          note_mismatch("hit", 8'(want.hit), 8'(hit));
        end
        if (add_status !== want.add_status) begin
          note_mismatch("add_status", 8'(want.add_status), 8'(add_status));
        end
      end
    end
  end

  // watchdog: any transaction, result or register write restarts the count
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_ranges_and_boundaries();
    test_capacity_limits();
    test_random_traffic();

    // drain, then allow for the longest scan before the final verdict
    wait_for_replies();
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (pending_replies.size() != 0) begin
      $display("%0d expected results never arrived", pending_replies.size());
      mismatch_count += pending_replies.size();
    end
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
